@@ sv/dbmt_pkg.sv @@
// ----------------------------------------------------------------------------
// Data block map table package
// Shared types, widths and codes for the block map table.
// ----------------------------------------------------------------------------
package dbmt_pkg;

    localparam int TABLE_DEPTH_DEF = 256;

    localparam int SERIAL_W = 16;
    localparam int INDEX_W  = 16;
    localparam int BLOCK_W  = 10;
    localparam int COUNT_W  = 9;
    localparam int STATUS_W = 2;

    typedef enum logic [1:0] {
        KIND_FIND   = 2'd0,
        KIND_INSERT = 2'd1,
        KIND_REMOVE = 2'd2,
        KIND_REMAP  = 2'd3
    } kind_t;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

    typedef struct packed {
        logic [SERIAL_W-1:0] serial;
        logic [INDEX_W-1:0]  index;
        logic [BLOCK_W-1:0]  block;
    } entry_t;

endpackage

@@ sv/dbmt_cell.sv @@
// ----------------------------------------------------------------------------
// Data block map table cell
// One storage cell that loads from either of two neighbors or holds.
// ----------------------------------------------------------------------------
module dbmt_cell #(
    parameter int W = $bits(dbmt_pkg::entry_t)
) (
    input  logic         clk,
    input  logic         ld_a,
    input  logic         ld_b,
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    output logic [W-1:0] q
);

    logic [W-1:0] q_reg;

    always_ff @(posedge clk)
    begin
        if (ld_b)
        begin
            q_reg <= b;
        end
        else if (ld_a)
        begin
            q_reg <= a;
        end
    end

    assign q = q_reg;

endmodule

@@ sv/data_block_map_table_core.sv @@
// ----------------------------------------------------------------------------
// Data block map table core
// The entries sit in a ring of TABLE_DEPTH cells that rotates one cell per
// cycle during a scan, past a single compare point at cell zero, so every
// scan brings each of the TABLE_DEPTH cells past that point once. Insert
// writes its entry without a scan, find and remap make one scan, and remove
// makes three: one pass counts the hits, one pass pushes the surviving tail
// entries onto a stack of TABLE_DEPTH / 2 cells, and one pass fills the holes
// from that stack. One operation is in flight at a time.
// ----------------------------------------------------------------------------
module data_block_map_table_core #(
    parameter int TABLE_DEPTH = dbmt_pkg::TABLE_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    kind,
    input  logic [dbmt_pkg::SERIAL_W-1:0] owner_serial,
    input  logic [dbmt_pkg::INDEX_W-1:0]  chunk_index,
    input  logic [dbmt_pkg::BLOCK_W-1:0]  block_num,
    input  logic [dbmt_pkg::BLOCK_W-1:0]  new_block_id,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [dbmt_pkg::STATUS_W-1:0] status,
    output logic [dbmt_pkg::BLOCK_W-1:0]  found_block,
    output logic [dbmt_pkg::COUNT_W-1:0]  entry_count
);

    localparam int PW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int SD = TABLE_DEPTH / 2;
    localparam int EW = $bits(dbmt_pkg::entry_t);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND,
        S_REMAP,
        S_RM_COUNT,
        S_RM_PUSH,
        S_RM_FILL,
        S_DONE
    } state_t;

    state_t                          state_reg;
    logic [PW-1:0]                   pos_reg;
    logic [CW-1:0]                   count_reg;
    logic [CW-1:0]                   keep_reg;
    logic [CW-1:0]                   hits_reg;
    logic                            found_reg;
    logic [dbmt_pkg::BLOCK_W-1:0]    fblk_reg;
    logic [dbmt_pkg::SERIAL_W-1:0]   ser_reg;
    logic [dbmt_pkg::INDEX_W-1:0]    idx_reg;
    logic [dbmt_pkg::BLOCK_W-1:0]    old_reg;
    logic [dbmt_pkg::BLOCK_W-1:0]    new_reg;
    logic [dbmt_pkg::STATUS_W-1:0]   res_status_reg;
    logic [dbmt_pkg::BLOCK_W-1:0]    res_block_reg;
    logic                            out_valid_reg;
    logic [dbmt_pkg::STATUS_W-1:0]   out_status_reg;
    logic [dbmt_pkg::BLOCK_W-1:0]    out_block_reg;
    logic [dbmt_pkg::COUNT_W-1:0]    out_count_reg;

    logic [EW-1:0]        ring_q [TABLE_DEPTH];
    logic [EW-1:0]        stk_q  [SD];
    dbmt_pkg::entry_t     head;
    dbmt_pkg::entry_t     head_new;
    dbmt_pkg::entry_t     wr_data;
    logic [CW-1:0]        pos_ext;
    logic                 in_range;
    logic                 upper;
    logic                 ser_hit;
    logic                 full_hit;
    logic                 find_now;
    logic                 shift_en;
    logic                 last;
    logic                 push;
    logic                 pop;
    logic                 in_acc;
    logic                 full;
    logic                 insert_wr;

    assign head     = dbmt_pkg::entry_t'(ring_q[0]);
    assign pos_ext  = CW'(pos_reg);
    assign in_range = pos_ext < count_reg;
    assign upper    = pos_ext >= keep_reg;
    assign ser_hit  = head.serial == ser_reg;
    assign full_hit = ser_hit && (head.index == idx_reg);
    assign find_now = in_range && full_hit && !found_reg;
    assign last     = pos_reg == PW'(TABLE_DEPTH - 1);
    assign shift_en = (state_reg == S_FIND) || (state_reg == S_REMAP) ||
                      (state_reg == S_RM_COUNT) || (state_reg == S_RM_PUSH) ||
                      (state_reg == S_RM_FILL);
    assign push     = (state_reg == S_RM_PUSH) && in_range && upper && !ser_hit;
    assign pop      = (state_reg == S_RM_FILL) && !upper && ser_hit;
    assign in_stall = state_reg != S_IDLE;
    assign in_acc   = in_valid && !in_stall;
    assign full     = count_reg == CW'(TABLE_DEPTH);
    assign insert_wr = in_acc && (dbmt_pkg::kind_t'(kind) == dbmt_pkg::KIND_INSERT) && !full;
    assign wr_data  = '{serial: owner_serial, index: chunk_index, block: block_num};

    always_comb
    begin
        head_new = head;
        if ((state_reg == S_REMAP) && in_range && (head.block == old_reg))
        begin
            head_new.block = new_reg;
        end
        if (pop)
        begin
            head_new = dbmt_pkg::entry_t'(stk_q[0]);
        end
    end

    for (genvar k = 0; k < TABLE_DEPTH; k++)
    begin : g_ring
        dbmt_cell #(.W(EW)) u_cell (
            .clk  (clk),
            .ld_a (shift_en),
            .ld_b (insert_wr && (count_reg == CW'(k))),
            .a    ((k == TABLE_DEPTH - 1) ? EW'(head_new) : ring_q[(k + 1) % TABLE_DEPTH]),
            .b    (EW'(wr_data)),
            .q    (ring_q[k])
        );
    end

    for (genvar j = 0; j < SD; j++)
    begin : g_stack
        dbmt_cell #(.W(EW)) u_cell (
            .clk  (clk),
            .ld_a (push),
            .ld_b (pop),
            .a    ((j == 0) ? EW'(head) : stk_q[(j + SD - 1) % SD]),
            .b    ((j == SD - 1) ? stk_q[j] : stk_q[(j + 1) % SD]),
            .q    (stk_q[j])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pos_reg        <= '0;
            count_reg      <= '0;
            keep_reg       <= '0;
            hits_reg       <= '0;
            found_reg      <= 1'b0;
            fblk_reg       <= '0;
            ser_reg        <= '0;
            idx_reg        <= '0;
            old_reg        <= '0;
            new_reg        <= '0;
            res_status_reg <= dbmt_pkg::ST_OK;
            res_block_reg  <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= dbmt_pkg::ST_OK;
            out_block_reg  <= '0;
            out_count_reg  <= '0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end
            if (shift_en)
            begin
                pos_reg <= last ? '0 : pos_reg + PW'(1);
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        ser_reg        <= owner_serial;
                        idx_reg        <= chunk_index;
                        old_reg        <= block_num;
                        new_reg        <= new_block_id;
                        pos_reg        <= '0;
                        found_reg      <= 1'b0;
                        hits_reg       <= '0;
                        res_status_reg <= dbmt_pkg::ST_OK;
                        res_block_reg  <= '0;
                        unique case (dbmt_pkg::kind_t'(kind))
                            dbmt_pkg::KIND_FIND:   state_reg <= S_FIND;
                            dbmt_pkg::KIND_REMOVE: state_reg <= S_RM_COUNT;
                            dbmt_pkg::KIND_REMAP:  state_reg <= S_REMAP;
                            dbmt_pkg::KIND_INSERT:
                            begin
                                if (full)
                                begin
                                    res_status_reg <= dbmt_pkg::ST_FULL;
                                end
                                else
                                begin
                                    count_reg <= count_reg + CW'(1);
                                end
                                state_reg <= S_DONE;
                            end
                            default: state_reg <= S_IDLE;
                        endcase
                    end
                end
                S_FIND:
                begin
                    if (find_now)
                    begin
                        found_reg <= 1'b1;
                        fblk_reg  <= head.block;
                    end
                    if (last)
                    begin
                        state_reg <= S_DONE;
                        if (found_reg)
                        begin
                            res_block_reg <= fblk_reg;
                        end
                        else if (find_now)
                        begin
                            res_block_reg <= head.block;
                        end
                        else
                        begin
                            res_status_reg <= dbmt_pkg::ST_NOT_FOUND;
                        end
                    end
                end
                S_REMAP:
                begin
                    if (last)
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_RM_COUNT:
                begin
                    if (in_range && ser_hit)
                    begin
                        hits_reg <= hits_reg + CW'(1);
                    end
                    if (last)
                    begin
                        keep_reg  <= count_reg - hits_reg - CW'(in_range && ser_hit);
                        state_reg <= S_RM_PUSH;
                    end
                end
                S_RM_PUSH:
                begin
                    if (last)
                    begin
                        state_reg <= S_RM_FILL;
                    end
                end
                S_RM_FILL:
                begin
                    if (last)
                    begin
                        count_reg <= keep_reg;
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= res_status_reg;
                        out_block_reg  <= res_block_reg;
                        out_count_reg  <= dbmt_pkg::COUNT_W'(count_reg);
                        state_reg      <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign found_block = out_block_reg;
    assign entry_count = out_count_reg;

endmodule

@@ sv/dbmt_checker.sv @@
// ----------------------------------------------------------------------------
// Data block map table checker
// Port-level assertions on the result channel, bound to the core.
// ----------------------------------------------------------------------------
module dbmt_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [dbmt_pkg::STATUS_W-1:0] status,
    input logic [dbmt_pkg::BLOCK_W-1:0]  found_block
);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result beat dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(status) && $stable(found_block))
        else $error("result beat changed while stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == dbmt_pkg::ST_OK) || (status == dbmt_pkg::ST_NOT_FOUND) ||
                      (status == dbmt_pkg::ST_FULL))
        else $error("undefined status code");

    a_block_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != dbmt_pkg::ST_OK) |-> found_block == '0)
        else $error("block number reported on a failed operation");

endmodule

bind data_block_map_table_core dbmt_checker u_dbmt_checker (.*);
